/* design/tkct_pkg.sv */
// Package for the top-k count tracker: transaction structs, command codes,
// cell control types and the ranking comparison. No dependencies.
package tkct_pkg;

    localparam int LIST_SIZE  = 10;
    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = 24;
    localparam int RANK_BITS  = 4;
    localparam int IDX_BITS   = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_OFFER = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code             command;
        logic [KEY_BITS-1:0]   item_key;
        logic [COUNT_BITS-1:0] item_count;
    } t_in_item;

    typedef struct packed {
        logic [RANK_BITS-1:0]  rank;
        logic [KEY_BITS-1:0]   out_key;
        logic [COUNT_BITS-1:0] out_count;
        logic                  present;
        logic                  last;
    } t_out_item;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_OFFER  = 2'd2,
        OP_ROTATE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_entry   offer;
    } t_cell_ctl;

    // True when entry a ranks strictly above entry b.
    function automatic logic ranks_above(input t_entry a, input t_entry b);
        if (a.count != b.count) begin
            return a.count > b.count;
        end
        return a.key < b.key;
    endfunction

endpackage

/* design/top_k_count_tracker.sv */
// Top level of the top-k count tracker: a chain of tkct_cell slots and the
// command and readout control. Depends on tkct_pkg and tkct_cell.

// A clear or an offer leaves busy low, so such commands may be given in every
// cycle while no readout runs. A readout holds busy high while the cells
// rotate once through slot zero; results leave one per cycle from the output
// register in the cycle after their slot passes slot zero. Empty slots are
// skipped except as the first result. The receiver cannot stall: each result
// is shown for exactly one cycle with o_result_strobe and must be taken then.
module top_k_count_tracker
    import tkct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_cmd,
    output logic      o_result_strobe,
    output t_out_item o_result
);

    localparam int NEXT0 = (LIST_SIZE > 1) ? 1 : 0;

    t_entry    w_entry  [LIST_SIZE];
    logic      w_beaten [LIST_SIZE];
    t_cell_ctl w_ctl;

    logic                r_reading;
    logic [IDX_BITS-1:0] r_idx;
    logic                r_strobe;
    t_out_item           r_result;
    logic                w_accept;
    logic                w_emit;
    logic                w_idx_end;

    assign busy     = r_reading;
    assign w_accept = start && !r_reading;

    always_comb begin
        w_ctl.op    = OP_HOLD;
        w_ctl.offer = '0;
        if (r_reading) begin
            w_ctl.op = OP_ROTATE;
        end else if (w_accept) begin
            case (i_cmd.command)
                CMD_CLEAR: begin
                    w_ctl.op = OP_CLEAR;
                end
                CMD_OFFER: begin
                    w_ctl.op          = OP_OFFER;
                    w_ctl.offer.key   = i_cmd.item_key;
                    w_ctl.offer.count = i_cmd.item_count;
                end
                default: begin
                    w_ctl.op = OP_HOLD;
                end
            endcase
        end
    end

    for (genvar g = 0; g < LIST_SIZE; g++) begin : g_cells
        t_entry w_prev;
        logic   w_prev_beaten;
        if (g == 0) begin : g_head
            assign w_prev        = '0;
            assign w_prev_beaten = 1'b0;
        end else begin : g_body
            assign w_prev        = w_entry[g-1];
            assign w_prev_beaten = w_beaten[g-1];
        end
        tkct_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_prev_entry  (w_prev),
            .i_prev_beaten (w_prev_beaten),
            .i_next_entry  (w_entry[(g + 1) % LIST_SIZE]),
            .o_entry       (w_entry[g]),
            .o_beaten      (w_beaten[g])
        );
    end

    // Filled slots always sit at the front, so the results end at the first
    // empty slot behind slot zero or at the end of the rotation.
    assign w_idx_end = (r_idx == IDX_BITS'(LIST_SIZE - 1));
    assign w_emit    = r_reading && ((w_entry[0].count != '0) || (r_idx == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading <= 1'b0;
            r_idx     <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= w_emit;
            if (r_reading) begin
                r_idx <= r_idx + 1'b1;
                if (w_idx_end) begin
                    r_reading <= 1'b0;
                    r_idx     <= '0;
                end
            end else if (w_accept && (i_cmd.command == CMD_READ)) begin
                r_reading <= 1'b1;
                r_idx     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_result.rank      <= RANK_BITS'(r_idx);
            r_result.out_key   <= w_entry[0].key;
            r_result.out_count <= w_entry[0].count;
            r_result.present   <= (w_entry[0].count != '0);
            r_result.last      <= w_idx_end || (w_entry[NEXT0].count == '0)
                                  || (w_entry[0].count == '0);
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

endmodule

/* design/tkct_cell.sv */
// One slot of the ranking chain: holds a (key, count) entry and hands it to
// its neighbours. Depends on tkct_pkg.
module tkct_cell
    import tkct_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_prev_entry,
    input  logic      i_prev_beaten,
    input  t_entry    i_next_entry,
    output t_entry    o_entry,
    output logic      o_beaten
);

    t_entry r_entry;
    t_entry n_entry;

    // A nonzero offer that outranks this slot's entry displaces it; if it
    // also displaced the slot above, this slot takes the shifted-down entry.
    assign o_beaten = (i_ctl.offer.count != '0) && ranks_above(i_ctl.offer, r_entry);
    assign o_entry  = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            OP_CLEAR: begin
                n_entry = '0;
            end
            OP_OFFER: begin
                if (o_beaten) begin
                    n_entry = i_prev_beaten ? i_prev_entry : i_ctl.offer;
                end
            end
            OP_ROTATE: begin
                n_entry = i_next_entry;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else begin
            r_entry <= n_entry;
        end
    end

endmodule
